>>> hdl/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro expects clk and rst to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/ilie_pkg.sv
// Shared types and codes for the indexed list block.
// No dependencies; used by the cells, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package ilie_pkg;

  // Index width covering every supported list depth and its length.
  localparam int unsigned IDX_W = 11;

  localparam logic [3:0] ACT_READ   = 4'd0;
  localparam logic [3:0] ACT_WRITE  = 4'd1;
  localparam logic [3:0] ACT_INSERT = 4'd2;
  localparam logic [3:0] ACT_ERASE  = 4'd3;
  localparam logic [3:0] ACT_PUSH   = 4'd4;
  localparam logic [3:0] ACT_POP    = 4'd5;
  localparam logic [3:0] ACT_CLEAR  = 4'd6;
  localparam logic [3:0] ACT_RESIZE = 4'd7;
  localparam logic [3:0] ACT_ASSIGN = 4'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_WRITE,
    OP_INSERT,
    OP_ERASE,
    OP_FILL
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } cell_cmd_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_pos;
    logic             last_en;
    logic [IDX_W-1:0] last_idx;
  } cell_probe_t;

endpackage

`default_nettype wire

>>> hdl/ilie_cell.sv
// One list entry: holds its word, loads, shifts from a neighbor or fills.
// Depends on ilie_pkg for the command and probe structs.
`timescale 1ns / 1ps
`default_nettype none

module ilie_cell
  import ilie_pkg::*;
#(
  parameter int unsigned INDEX = 0
) (
  input  wire logic        clk,
  input  wire cell_cmd_t   cmd,
  input  wire logic [31:0] value,
  input  wire logic [31:0] left,
  input  wire logic [31:0] right,
  input  wire cell_probe_t probe,
  output logic [31:0]      entry,
  output logic [31:0]      rd_part,
  output logic [31:0]      last_part
);

  localparam logic [IDX_W-1:0] IDX = IDX_W'(INDEX);

  logic [31:0] entry_next;

  always_comb begin
    entry_next = entry;
    unique case (cmd.op)
      OP_HOLD: entry_next = entry;
      OP_WRITE: begin
        if (IDX == cmd.pos) entry_next = value;
      end
      OP_INSERT: begin
        if (IDX == cmd.pos) entry_next = value;
        else if (IDX > cmd.pos) entry_next = left;
      end
      OP_ERASE: begin
        if (IDX >= cmd.pos) entry_next = right;
      end
      OP_FILL: begin
        if (IDX >= cmd.lo && IDX < cmd.hi) entry_next = value;
      end
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  assign rd_part   = (probe.rd_en && IDX == probe.rd_pos) ? entry : '0;
  assign last_part = (probe.last_en && IDX == probe.last_idx) ? entry : '0;

endmodule

`default_nettype wire

>>> hdl/indexed_list_insert_erase.sv
// Top level of the indexed list: control, length register and result stage.
// Depends on ilie_pkg and instantiates a row of ilie_cell.
`timescale 1ns / 1ps
`default_nettype none

// An ordered list of up to DEPTH signed 32-bit words held in a row of cells,
// one word per cell. Insert shifts every cell above the position up by one
// and erase shifts them down, all cells moving in the same cycle. For each
// item the cells and the length update at the accepting edge; the result
// (read word, first and last word, length, status) is then formed from the
// updated row into the output register. A new item is taken only after the
// last one's result is registered; a held result only stalls the block once
// the following result is ready to be registered.
module indexed_list_insert_erase
  import ilie_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire logic [3:0]         action,
  input  wire logic [4:0]         position,
  input  wire logic signed [31:0] item_value,
  input  wire logic [4:0]         new_length,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output logic signed [31:0]      read_value,
  output logic signed [31:0]      first_value,
  output logic signed [31:0]      last_value,
  output logic [4:0]              length_now,
  output logic                    is_empty,
  output logic [1:0]              status
);

  localparam int unsigned LW = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] DEPTH_X = IDX_W'(DEPTH);

  logic [LW-1:0]    len;
  logic [LW-1:0]    len_next;
  logic             busy;
  logic             rd_ok;
  logic             rd_ok_next;
  logic [IDX_W-1:0] rd_pos;
  logic [1:0]       st;
  logic [1:0]       st_next;
  logic             accept;
  logic             load_out;

  cell_cmd_t   cmd;
  cell_probe_t probe;

  logic [IDX_W-1:0] pos_x;
  logic [IDX_W-1:0] len_x;
  logic [IDX_W-1:0] nlen_x;

  logic [31:0] entries   [DEPTH];
  logic [31:0] rd_parts  [DEPTH];
  logic [31:0] last_parts[DEPTH];
  logic [31:0] rd_word;
  logic [31:0] last_word;

  assign req_ready = !busy;
  assign accept    = req_valid && req_ready;
  assign load_out  = busy && (!rsp_valid || rsp_ready);

  assign pos_x  = IDX_W'(position);
  assign len_x  = IDX_W'(len);
  assign nlen_x = IDX_W'(new_length);

  always_comb begin
    cmd        = '{op: OP_HOLD, pos: pos_x, lo: len_x, hi: len_x + IDX_W'(1)};
    len_next   = len;
    st_next    = ST_OK;
    rd_ok_next = 1'b0;
    unique case (action)
      ACT_READ: begin
        if (pos_x >= len_x) st_next = ST_RANGE;
        else rd_ok_next = 1'b1;
      end
      ACT_WRITE: begin
        if (pos_x >= len_x) st_next = ST_RANGE;
        else cmd.op = OP_WRITE;
      end
      ACT_INSERT: begin
        if (pos_x > len_x) begin
          st_next = ST_RANGE;
        end else if (len_x >= DEPTH_X) begin
          st_next = ST_FULL;
        end else begin
          cmd.op   = OP_INSERT;
          len_next = len + LW'(1);
        end
      end
      ACT_ERASE: begin
        if (pos_x >= len_x) begin
          st_next = ST_RANGE;
        end else begin
          cmd.op   = OP_ERASE;
          len_next = len - LW'(1);
        end
      end
      ACT_PUSH: begin
        if (len_x >= DEPTH_X) begin
          st_next = ST_FULL;
        end else begin
          cmd.op   = OP_FILL;
          len_next = len + LW'(1);
        end
      end
      ACT_POP: begin
        if (len == '0) st_next = ST_EMPTY;
        else len_next = len - LW'(1);
      end
      ACT_CLEAR: len_next = '0;
      ACT_RESIZE: begin
        if (nlen_x > DEPTH_X) begin
          st_next = ST_FULL;
        end else begin
          cmd.op   = OP_FILL;
          cmd.hi   = nlen_x;
          len_next = LW'(nlen_x);
        end
      end
      ACT_ASSIGN: begin
        if (nlen_x > DEPTH_X) begin
          st_next = ST_FULL;
        end else begin
          cmd.op   = OP_FILL;
          cmd.lo   = '0;
          cmd.hi   = nlen_x;
          len_next = LW'(nlen_x);
        end
      end
      default: st_next = ST_RANGE;
    endcase
    if (!accept) begin
      cmd.op   = OP_HOLD;
      len_next = len;
    end
  end

  assign probe = '{
    rd_en:    rd_ok,
    rd_pos:   rd_pos,
    last_en:  len != '0,
    last_idx: len_x - IDX_W'(1)
  };

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] left_in;
    logic [31:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid
      assign left_in = entries[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_inner
      assign right_in = entries[i+1];
    end
    ilie_cell #(
      .INDEX(i)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .value    (item_value),
      .left     (left_in),
      .right    (right_in),
      .probe    (probe),
      .entry    (entries[i]),
      .rd_part  (rd_parts[i]),
      .last_part(last_parts[i])
    );
  end

  always_comb begin
    rd_word   = '0;
    last_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word   = rd_word | rd_parts[i];
      last_word = last_word | last_parts[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      len <= len_next;
      if (accept) begin
        busy <= 1'b1;
      end else if (load_out) begin
        busy <= 1'b0;
      end
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_ok  <= rd_ok_next;
      rd_pos <= pos_x;
      st     <= st_next;
    end
    if (load_out) begin
      read_value  <= $signed(rd_word);
      first_value <= (len != '0) ? $signed(entries[0]) : '0;
      last_value  <= $signed(last_word);
      length_now  <= 5'(len);
      is_empty    <= (len == '0);
      status      <= st;
    end
  end

endmodule

`default_nettype wire

>>> hdl/ilie_checker.sv
// Port-level checks for the indexed list, bound to the top level.
// Depends on ilie_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ilie_checker
  import ilie_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_ready,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire logic signed [31:0] read_value,
  input wire logic signed [31:0] first_value,
  input wire logic signed [31:0] last_value,
  input wire logic [4:0]         length_now,
  input wire logic               is_empty,
  input wire logic [1:0]         status
);

  `ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
  `ASSERT_IMPL(a_empty_flag, rsp_valid, is_empty == (length_now == 5'd0))
  `ASSERT_IMPL(a_empty_ends, rsp_valid && is_empty, first_value == 0 && last_value == 0)
  `ASSERT_IMPL(a_fail_no_read, rsp_valid && status != ST_OK, read_value == 0)
  `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(read_value))

endmodule

bind indexed_list_insert_erase ilie_checker u_ilie_checker (.*);

`default_nettype wire
